FILE: hw/rtl/arcp_pkg.sv
// Shared constants, types and helper functions of the ASCII register command parser.
`default_nettype none

package arcp_pkg;

    localparam int NUM_REGS_DEFAULT = 20;
    localparam int PTR_W            = 5;
    localparam int ADDR_W           = 7;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [ADDR_W-1:0] DEV_ADDR_RESET = 7'd77;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_SEMI   = 8'h3b;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_QUERY  = 8'h3f;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_G  = 8'h67;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_TILDE  = 8'h7e;

    typedef enum logic [1:0] {
        RX_LISTEN = 2'd0,
        RX_GETREG = 2'd1,
        RX_GETVAL = 2'd2
    } t_rx_mode;

    typedef enum logic [1:0] {
        RUN_IDLE    = 2'd0,
        RUN_RESET   = 2'd1,
        RUN_RUNNING = 2'd2
    } t_run_state;

    typedef enum logic [2:0] {
        CLS_UNKNOWN  = 3'd0,
        CLS_ADDRESS  = 3'd1,
        CLS_NUMERAL  = 3'd2,
        CLS_COMMAND  = 3'd3,
        CLS_REGISTER = 3'd4,
        CLS_NEWLINE  = 3'd5
    } t_cls;

    typedef enum logic [1:0] {
        RESP_NONE = 2'd0,
        RESP_CHAR = 2'd1,
        RESP_HEX  = 2'd2
    } t_resp_kind;

    typedef struct packed {
        t_resp_kind kind;
        logic [7:0] data;
        logic [1:0] run_mode;
        logic       zero;
    } t_resp;

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_0 + {4'h0, n};
        end else begin
            r = CH_LOW_A + {4'h0, n} - 8'd10;
        end
        return r;
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = CLS_ADDRESS;
        end else if ((c >= CH_0 && c <= CH_9) || (c >= CH_LOW_A && c <= CH_LOW_F)) begin
            r = CLS_NUMERAL;
        end else if (c >= CH_LOW_G && c <= CH_LOW_Z) begin
            r = CLS_REGISTER;
        end else if ((c >= CH_SPACE && c <= CH_SLASH) || (c >= CH_COLON && c <= CH_AT) ||
                     (c >= CH_LBRACK && c <= CH_BTICK) ||
                     (c >= CH_LBRACE && c <= CH_TILDE)) begin
            r = CLS_COMMAND;
        end else if (c == CH_LF || c == CH_CR) begin
            r = CLS_NEWLINE;
        end else begin
            r = CLS_UNKNOWN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arcp_rx_if.sv
// Receive channel interface carrying one byte per transfer.
`default_nettype none

interface arcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/arcp_tx_if.sv
// Result channel interface carrying one response result per transfer.
`default_nettype none

interface arcp_tx_if;
    logic       valid;
    logic       ready;
    logic       has_char;
    logic [7:0] tx_char;
    logic       last_of_run;
    logic [1:0] run_mode;
    logic       zero_encoder;

    modport source(output valid, output has_char, output tx_char, output last_of_run,
                   output run_mode, output zero_encoder, input ready);
    modport sink(input valid, input has_char, input tx_char, input last_of_run,
                 input run_mode, input zero_encoder, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/arcp_front.sv
// Front end: byte classification, receive state machine, register file and run state.
`default_nettype none

module arcp_front #(
    parameter int NUM_REGS = arcp_pkg::NUM_REGS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [arcp_pkg::ADDR_W-1:0] i_cfg_wr_data,
    input  logic                        i_accept,
    input  logic [7:0]                  i_byte,
    output arcp_pkg::t_resp             o_resp
);
    import arcp_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [ADDR_W-1:0] r_dev_addr;
    t_rx_mode          r_mode;
    t_rx_mode          n_mode;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  n_ptr;
    logic [7:0]        r_accum;
    logic [7:0]        n_accum;
    t_run_state        r_run;
    t_run_state        n_run;
    logic [7:0]        r_regs [NUM_REGS];

    t_cls       cls;
    logic       is_dev;
    logic       ptr_ok;
    logic [7:0] rd_val;
    logic [3:0] digit;
    logic       wr_en;
    t_resp_kind kind;
    logic [7:0] data;
    logic       zero;

    assign cls    = classify(i_byte);
    assign is_dev = (i_byte == {1'b0, r_dev_addr});
    assign ptr_ok = (r_ptr < PTR_W'(NUM_REGS));
    assign rd_val = ptr_ok ? r_regs[r_ptr[IDX_W-1:0]] : 8'h00;
    assign digit  = (i_byte <= CH_9) ? i_byte[3:0] : i_byte[3:0] + 4'd9;

    always_comb begin
        n_mode = r_mode;
        if (cls == CLS_ADDRESS) begin
            n_mode = is_dev ? RX_GETREG : RX_LISTEN;
        end else begin
            unique case (r_mode)
                RX_GETREG: begin
                    if (cls == CLS_REGISTER) begin
                        n_mode = RX_GETVAL;
                    end else if (cls == CLS_COMMAND) begin
                        n_mode = RX_LISTEN;
                    end
                end
                RX_GETVAL: begin
                    if (cls == CLS_NEWLINE || cls == CLS_COMMAND) begin
                        n_mode = RX_LISTEN;
                    end
                end
                default: n_mode = RX_LISTEN;
            endcase
        end
    end

    always_comb begin
        n_ptr   = r_ptr;
        n_accum = r_accum;
        n_run   = r_run;
        wr_en   = 1'b0;
        kind    = RESP_NONE;
        data    = 8'h00;
        zero    = 1'b0;
        if (cls != CLS_ADDRESS) begin
            unique case (r_mode)
                RX_GETREG: begin
                    if (cls == CLS_REGISTER) begin
                        n_ptr = PTR_W'(i_byte - CH_LOW_G);
                    end else if (cls == CLS_COMMAND) begin
                        unique case (i_byte)
                            CH_QUERY: begin
                                kind = RESP_CHAR;
                                data = {1'b0, r_dev_addr};
                            end
                            CH_AT: begin
                                kind = RESP_CHAR;
                                data = {3'b000, r_ptr} + CH_LOW_G;
                            end
                            CH_HASH: begin
                                kind = RESP_HEX;
                                data = r_accum;
                            end
                            CH_SEMI: begin
                                kind = RESP_HEX;
                                data = {6'b000000, r_run};
                            end
                            CH_DOT:   n_run = RUN_IDLE;
                            CH_LT:    n_run = RUN_RESET;
                            CH_GT:    n_run = RUN_RUNNING;
                            CH_TILDE: zero  = 1'b1;
                            default: ;
                        endcase
                    end
                end
                RX_GETVAL: begin
                    if (cls == CLS_NUMERAL) begin
                        n_accum = {r_accum[3:0], digit};
                    end else if (cls == CLS_NEWLINE) begin
                        wr_en   = ptr_ok;
                        n_ptr   = '0;
                        n_accum = 8'h00;
                    end else if (cls == CLS_COMMAND && i_byte == CH_QUERY) begin
                        kind = RESP_HEX;
                        data = rd_val;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_resp = '{kind: kind, data: data, run_mode: n_run, zero: zero};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
            r_mode     <= RX_LISTEN;
            r_ptr      <= '0;
            r_accum    <= 8'h00;
            r_run      <= RUN_IDLE;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 8'h00;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_dev_addr <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_mode  <= n_mode;
                r_ptr   <= n_ptr;
                r_accum <= n_accum;
                r_run   <= n_run;
                if (wr_en) begin
                    r_regs[r_ptr[IDX_W-1:0]] <= r_accum;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/arcp_fifo.sv
// Short queue of response descriptors between the front end and the back end.
`default_nettype none

module arcp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  arcp_pkg::t_resp i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output arcp_pkg::t_resp o_pop_data,
    output logic            o_empty
);
    import arcp_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    t_resp             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/arcp_back.sv
// Back end: expands each response descriptor into result transfers through an output register.
`default_nettype none

module arcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  arcp_pkg::t_resp i_desc,
    output logic            o_pop,
    arcp_tx_if.source       o_tx
);
    import arcp_pkg::*;

    logic       r_act;
    t_resp      r_desc;
    logic [1:0] r_idx;
    logic       r_ov;
    logic       r_has;
    logic [7:0] r_char;
    logic       r_last;
    logic [1:0] r_run;
    logic       r_zero;

    logic       out_free;
    logic       emit;
    logic       it_has;
    logic [7:0] it_char;
    logic       it_last;

    always_comb begin
        it_has  = 1'b1;
        it_char = CH_LF;
        it_last = 1'b0;
        unique case (r_desc.kind)
            RESP_CHAR: begin
                unique case (r_idx)
                    2'd0:    it_char = r_desc.data;
                    2'd1:    it_char = CH_CR;
                    default: it_char = CH_LF;
                endcase
                it_last = (r_idx == 2'd2);
            end
            RESP_HEX: begin
                unique case (r_idx)
                    2'd0:    it_char = nibble_char(r_desc.data[7:4]);
                    2'd1:    it_char = nibble_char(r_desc.data[3:0]);
                    2'd2:    it_char = CH_CR;
                    default: it_char = CH_LF;
                endcase
                it_last = (r_idx == 2'd3);
            end
            default: begin
                it_has  = 1'b0;
                it_char = 8'h00;
                it_last = 1'b1;
            end
        endcase
    end

    assign out_free = !r_ov || o_tx.ready;
    assign emit     = r_act && out_free;
    assign o_pop    = !i_empty && (!r_act || (emit && it_last));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        if (emit) begin
            r_has  <= it_has;
            r_char <= it_char;
            r_last <= it_last;
            r_run  <= r_desc.run_mode;
            r_zero <= r_desc.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= 2'd0;
            r_ov  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= 2'd0;
            end else if (emit) begin
                if (it_last) begin
                    r_act <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_tx.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_tx.valid        = r_ov;
    assign o_tx.has_char     = r_has;
    assign o_tx.tx_char      = r_char;
    assign o_tx.last_of_run  = r_last;
    assign o_tx.run_mode     = r_run;
    assign o_tx.zero_encoder = r_zero;

endmodule

`default_nettype wire

FILE: hw/rtl/ascii_register_command_parser_core.sv
// Top level of the ASCII register command parser.
// The parser takes received bytes on the i_rx channel, one byte per transfer, and
// gives result transfers on the o_tx channel. Every byte yields one to four results:
// one per response character, or a single result without a character, with the
// last result of the byte marked by last_of_run. i_cfg_wr_en with i_cfg_wr_data
// writes the device address letter; write it only while the parser is idle.
// A byte is classified and carried out in the cycle it is accepted, and its response
// descriptor enters a four-entry queue. The back end expands a descriptor at one
// result per cycle, while its output register is free, into that register, so the
// first result of a byte passes the queue, the back end's descriptor register and
// the output register. A new byte is accepted every cycle while the queue has room,
// so sustained throughput is set by the back end: one result per cycle unless stalled.
// Synchronous reset clears the receive mode, register pointer, accumulator, run
// state, all registers of the file and the queue, and sets the address to 'M'.
// When the receiver stalls, the output register holds its result, the back end
// stops, and the queue fills until i_rx.ready drops.
`default_nettype none

module ascii_register_command_parser_core #(
    parameter int NUM_REGS = arcp_pkg::NUM_REGS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [arcp_pkg::ADDR_W-1:0] i_cfg_wr_data,
    arcp_rx_if.sink                     i_rx,
    arcp_tx_if.source                   o_tx
);
    import arcp_pkg::*;

    t_resp front_resp;
    t_resp queue_head;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;
    logic  rx_accept;

    assign i_rx.ready = !queue_full;
    assign rx_accept  = i_rx.valid && i_rx.ready;

    arcp_front #(
        .NUM_REGS(NUM_REGS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (rx_accept),
        .i_byte       (i_rx.rx_byte),
        .o_resp       (front_resp)
    );

    arcp_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (rx_accept),
        .i_push_data(front_resp),
        .o_full     (queue_full),
        .i_pop      (queue_pop),
        .o_pop_data (queue_head),
        .o_empty    (queue_empty)
    );

    arcp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(queue_empty),
        .i_desc (queue_head),
        .o_pop  (queue_pop),
        .o_tx   (o_tx)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/arcp_checker.sv
// Port-level assertion checker for the parser top level, with its bind statement.
`default_nettype none

module arcp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_tx_valid,
    input logic       i_tx_ready,
    input logic       i_has_char,
    input logic [7:0] i_tx_char,
    input logic       i_last,
    input logic       i_zero
);
    import arcp_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_tx_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tx_valid && !i_tx_ready |=> i_tx_valid && $stable(i_tx_char) &&
            $stable(i_has_char) && $stable(i_last))
        else $error("stalled result changed");

    a_empty_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tx_valid && !i_has_char |-> i_tx_char == 8'h00 && i_last)
        else $error("result without character is malformed");

    a_line_ends_in_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tx_valid && i_has_char && i_last |-> i_tx_char == CH_LF)
        else $error("response line does not end in LF");

    a_zero_has_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tx_valid && i_zero |-> !i_has_char && i_last)
        else $error("encoder zeroing with a response character");

endmodule

bind ascii_register_command_parser_core arcp_checker u_arcp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_tx_valid(o_tx.valid),
    .i_tx_ready(o_tx.ready),
    .i_has_char(o_tx.has_char),
    .i_tx_char (o_tx.tx_char),
    .i_last    (o_tx.last_of_run),
    .i_zero    (o_tx.zero_encoder)
);

`default_nettype wire
